FILE: design/qihp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qihp_pkg
// Shared types, codes and defaults of the QUIC Initial header parser.
// ----------------------------------------------------------------------------
package qihp_pkg;

  localparam int MaxPacketBytes = 4096;
  localparam int MaxCidBytes    = 20;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int OutDataW = 72;

  localparam logic [CfgIdxW-1:0] CFG_VERSION_ONE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VERSION_TWO = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_PAYLOAD = 2'd2;

  localparam logic [31:0] VERSION_ONE_RESET = 32'h0000_0001;
  localparam logic [31:0] VERSION_TWO_RESET = 32'h6b33_43cf;
  localparam logic [11:0] MIN_PAYLOAD_RESET = 12'd20;

  localparam int MinDcidBytes = 8;
  localparam int ShortPacket  = 6;

  localparam logic [3:0] CLS_HDR  = 4'd0;
  localparam logic [3:0] CLS_DLEN = 4'd1;
  localparam logic [3:0] CLS_DCID = 4'd2;
  localparam logic [3:0] CLS_SLEN = 4'd3;
  localparam logic [3:0] CLS_SCID = 4'd4;
  localparam logic [3:0] CLS_TVAR = 4'd5;
  localparam logic [3:0] CLS_TOK  = 4'd6;
  localparam logic [3:0] CLS_LVAR = 4'd7;
  localparam logic [3:0] CLS_REST = 4'd8;
  localparam logic [3:0] CLS_ERR  = 4'd9;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_TRUNCATED   = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    PH_HDR  = 10'b00_0000_0001,
    PH_DLEN = 10'b00_0000_0010,
    PH_DCID = 10'b00_0000_0100,
    PH_SLEN = 10'b00_0000_1000,
    PH_SCID = 10'b00_0001_0000,
    PH_TVAR = 10'b00_0010_0000,
    PH_TOK  = 10'b00_0100_0000,
    PH_LVAR = 10'b00_1000_0000,
    PH_REST = 10'b01_0000_0000,
    PH_ERR  = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [3:0]  byte_class;
    logic        packet_done;
    status_e     status;
    logic        is_version_two;
    logic [4:0]  dcid_length;
    logic [4:0]  scid_length;
    logic [11:0] token_pos;
    logic [11:0] token_length;
    logic [11:0] payload_pos;
    logic [11:0] payload_length;
  } res_t;

  function automatic logic [3:0] phase_class(phase_e ph);
    logic [3:0] cls;
    case (ph)
      PH_HDR:  cls = CLS_HDR;
      PH_DLEN: cls = CLS_DLEN;
      PH_DCID: cls = CLS_DCID;
      PH_SLEN: cls = CLS_SLEN;
      PH_SCID: cls = CLS_SCID;
      PH_TVAR: cls = CLS_TVAR;
      PH_TOK:  cls = CLS_TOK;
      PH_LVAR: cls = CLS_LVAR;
      PH_REST: cls = CLS_REST;
      default: cls = CLS_ERR;
    endcase
    return cls;
  endfunction

endpackage

FILE: design/qihp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qihp_in_reg
// Input register stage; takes a new byte when empty or whenever the parse stage moves on.
// ----------------------------------------------------------------------------
module qihp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  qihp_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           advance_i,
  output qihp_pkg::item_t item_o
);

  logic            valid_q;
  qihp_pkg::item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: design/qihp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qihp_parse
// Per-byte header state machine, configuration registers and result logic.
// ----------------------------------------------------------------------------
module qihp_parse #(
  parameter int MAX_PACKET_BYTES = qihp_pkg::MaxPacketBytes,
  parameter int MAX_CID_BYTES    = qihp_pkg::MaxCidBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qihp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qihp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          fire_i,
  input  qihp_pkg::item_t               item_i,
  output qihp_pkg::res_t                result_o
);

  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CidW = $clog2(MAX_CID_BYTES + 1);
  localparam int RemW = (PosW > CidW) ? PosW : CidW;

  logic [31:0] ver_one_q;
  logic [31:0] ver_two_q;
  logic [11:0] min_pay_q;

  logic [PosW-1:0]       pos_q, pos_d;
  qihp_pkg::phase_e      phase_q, phase_d;
  qihp_pkg::status_e     err_q, err_d;
  logic                  hdr_bad_q, hdr_bad_d;
  logic [1:0]            type_q, type_d;
  logic [31:0]           ver_q, ver_d;
  logic                  kind_q, kind_d;
  logic [CidW-1:0]       dcnt_q, dcnt_d;
  logic [CidW-1:0]       scnt_q, scnt_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic [PosW-1:0]       acc_q, acc_d;
  logic [2:0]            vleft_q, vleft_d;
  logic [11:0]           tok_start_q, tok_start_d;
  logic [11:0]           tok_size_q, tok_size_d;
  logic [11:0]           pay_start_q, pay_start_d;
  logic [PosW-1:0]       pay_size_q, pay_size_d;

  logic [PosW-1:0]   acc_n;
  logic [2:0]        vleft_n;
  logic              vdone;
  logic [PosW+7:0]   acc_wide;
  logic              fail_req;
  qihp_pkg::status_e fail_code;
  logic              hdr_end;
  logic [7:0]        b;
  logic [PosW-1:0]   pos_inc;
  qihp_pkg::status_e status;
  logic [3:0]        cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_one_q <= qihp_pkg::VERSION_ONE_RESET;
      ver_two_q <= qihp_pkg::VERSION_TWO_RESET;
      min_pay_q <= qihp_pkg::MIN_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qihp_pkg::CFG_VERSION_ONE: ver_one_q <= cfg_data_i;
        qihp_pkg::CFG_VERSION_TWO: ver_two_q <= cfg_data_i;
        qihp_pkg::CFG_MIN_PAYLOAD: min_pay_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // varint byte step
  always_comb begin
    acc_wide = {acc_q, 8'h00} | (PosW + 8)'(b);
    if (vleft_q == 3'd0) begin
      acc_n   = PosW'(b[5:0]);
      vleft_n = 3'((4'd1 << b[7:6]) - 4'd1);
    end else begin
      if (acc_wide > (PosW + 8)'(MAX_PACKET_BYTES)) begin
        acc_n = PosW'(MAX_PACKET_BYTES);
      end else begin
        acc_n = PosW'(acc_wide);
      end
      vleft_n = vleft_q - 3'd1;
    end
    vdone = (vleft_n == 3'd0);
  end

  assign b       = item_i.data;
  assign pos_inc = pos_q + 1'b1;

  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    err_d       = err_q;
    hdr_bad_d   = hdr_bad_q;
    type_d      = type_q;
    ver_d       = ver_q;
    kind_d      = kind_q;
    dcnt_d      = dcnt_q;
    scnt_d      = scnt_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    vleft_d     = vleft_q;
    tok_start_d = tok_start_q;
    tok_size_d  = tok_size_q;
    pay_start_d = pay_start_q;
    pay_size_d  = pay_size_q;
    fail_req    = 1'b0;
    fail_code   = qihp_pkg::ST_INVALID;
    hdr_end     = 1'b0;
    cls         = qihp_pkg::CLS_ERR;

    if (pos_q >= PosW'(MAX_PACKET_BYTES)) begin
      fail_req = 1'b1;
    end else begin
      cls   = qihp_pkg::phase_class(phase_q);
      pos_d = pos_inc;
      case (phase_q)
        qihp_pkg::PH_HDR: begin
          if (pos_q == '0) begin
            type_d = b[5:4];
            if (!b[7] || !b[6]) begin
              fail_req = 1'b1;
            end
          end else begin
            ver_d = {ver_q[23:0], b};
            if (pos_q == PosW'(4)) begin
              if (ver_d == ver_one_q) begin
                kind_d    = 1'b0;
                hdr_bad_d = (type_q != 2'd0);
                phase_d   = qihp_pkg::PH_DLEN;
              end else if (ver_d == ver_two_q) begin
                kind_d    = 1'b1;
                hdr_bad_d = (type_q != 2'd1);
                phase_d   = qihp_pkg::PH_DLEN;
              end else begin
                fail_req  = 1'b1;
                fail_code = qihp_pkg::ST_UNSUPPORTED;
              end
            end
          end
        end
        qihp_pkg::PH_DLEN: begin
          if ({1'b0, b} > 9'(MAX_CID_BYTES)) begin
            fail_req = 1'b1;
          end else begin
            dcnt_d  = CidW'(b);
            rem_d   = RemW'(b);
            phase_d = (b != 8'd0) ? qihp_pkg::PH_DCID : qihp_pkg::PH_SLEN;
          end
        end
        qihp_pkg::PH_DCID: begin
          rem_d = rem_q - 1'b1;
          if (rem_d == '0) begin
            phase_d = qihp_pkg::PH_SLEN;
          end
        end
        qihp_pkg::PH_SLEN: begin
          if ({1'b0, b} > 9'(MAX_CID_BYTES)) begin
            fail_req = 1'b1;
          end else begin
            scnt_d = CidW'(b);
            rem_d  = RemW'(b);
            if (b != 8'd0) begin
              phase_d = qihp_pkg::PH_SCID;
            end else begin
              hdr_end = 1'b1;
            end
          end
        end
        qihp_pkg::PH_SCID: begin
          rem_d = rem_q - 1'b1;
          if (rem_d == '0) begin
            hdr_end = 1'b1;
          end
        end
        qihp_pkg::PH_TVAR: begin
          acc_d   = acc_n;
          vleft_d = vleft_n;
          if (vdone) begin
            tok_start_d = 12'({1'b0, pos_inc});
            tok_size_d  = 12'({1'b0, acc_n});
            rem_d       = RemW'(acc_n);
            vleft_d     = 3'd0;
            phase_d     = (acc_n != '0) ? qihp_pkg::PH_TOK : qihp_pkg::PH_LVAR;
          end
        end
        qihp_pkg::PH_TOK: begin
          rem_d = rem_q - 1'b1;
          if (rem_d == '0) begin
            vleft_d = 3'd0;
            phase_d = qihp_pkg::PH_LVAR;
          end
        end
        qihp_pkg::PH_LVAR: begin
          acc_d   = acc_n;
          vleft_d = vleft_n;
          if (vdone) begin
            pay_start_d = 12'({1'b0, pos_inc});
            pay_size_d  = acc_n;
            rem_d       = RemW'(acc_n);
            phase_d     = qihp_pkg::PH_REST;
          end
        end
        qihp_pkg::PH_REST: begin
          if (rem_q != '0) begin
            rem_d = rem_q - 1'b1;
          end
        end
        default: begin
          cls     = qihp_pkg::CLS_ERR;
          phase_d = qihp_pkg::PH_ERR;
        end
      endcase
    end

    // header complete after the source cid
    if (hdr_end) begin
      if (hdr_bad_q || (dcnt_q < CidW'(qihp_pkg::MinDcidBytes))) begin
        fail_req = 1'b1;
      end else begin
        phase_d = qihp_pkg::PH_TVAR;
        vleft_d = 3'd0;
      end
    end

    if (fail_req) begin
      if (err_q == qihp_pkg::ST_OK) begin
        err_d = fail_code;
      end
      phase_d = qihp_pkg::PH_ERR;
    end
  end

  always_comb begin
    status = qihp_pkg::ST_OK;
    if (pos_q < PosW'(qihp_pkg::ShortPacket)) begin
      status = qihp_pkg::ST_TRUNCATED;
    end else if (err_d != qihp_pkg::ST_OK) begin
      status = err_d;
    end else begin
      case (phase_d)
        qihp_pkg::PH_DCID, qihp_pkg::PH_SCID: status = qihp_pkg::ST_INVALID;
        qihp_pkg::PH_SLEN, qihp_pkg::PH_TOK:  status = qihp_pkg::ST_TRUNCATED;
        qihp_pkg::PH_TVAR, qihp_pkg::PH_LVAR: begin
          status = (vleft_d == 3'd0) ? qihp_pkg::ST_INVALID : qihp_pkg::ST_TRUNCATED;
        end
        qihp_pkg::PH_REST: begin
          if (rem_d != '0) begin
            status = qihp_pkg::ST_TRUNCATED;
          end else if (32'(pay_size_d) < 32'(min_pay_q)) begin
            status = qihp_pkg::ST_INVALID;
          end else begin
            status = qihp_pkg::ST_OK;
          end
        end
        default: status = qihp_pkg::ST_INVALID;
      endcase
    end
  end

  always_comb begin
    result_o                = '0;
    result_o.byte_class     = cls;
    result_o.packet_done    = item_i.last;
    if (item_i.last) begin
      result_o.status = status;
      if (status == qihp_pkg::ST_OK) begin
        result_o.is_version_two = kind_d;
        result_o.dcid_length    = 5'(dcnt_d);
        result_o.scid_length    = 5'(scnt_d);
        result_o.token_pos      = tok_start_d;
        result_o.token_length   = tok_size_d;
        result_o.payload_pos    = pay_start_d;
        result_o.payload_length = 12'({1'b0, pay_size_d});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= qihp_pkg::PH_HDR;
      err_q       <= qihp_pkg::ST_OK;
      hdr_bad_q   <= 1'b0;
      type_q      <= '0;
      ver_q       <= '0;
      kind_q      <= 1'b0;
      dcnt_q      <= '0;
      scnt_q      <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      vleft_q     <= '0;
      tok_start_q <= '0;
      tok_size_q  <= '0;
      pay_start_q <= '0;
      pay_size_q  <= '0;
    end else if (fire_i) begin
      if (item_i.last) begin
        pos_q       <= '0;
        phase_q     <= qihp_pkg::PH_HDR;
        err_q       <= qihp_pkg::ST_OK;
        hdr_bad_q   <= 1'b0;
        type_q      <= '0;
        ver_q       <= '0;
        kind_q      <= 1'b0;
        dcnt_q      <= '0;
        scnt_q      <= '0;
        rem_q       <= '0;
        acc_q       <= '0;
        vleft_q     <= '0;
        tok_start_q <= '0;
        tok_size_q  <= '0;
        pay_start_q <= '0;
        pay_size_q  <= '0;
      end else begin
        pos_q       <= pos_d;
        phase_q     <= phase_d;
        err_q       <= err_d;
        hdr_bad_q   <= hdr_bad_d;
        type_q      <= type_d;
        ver_q       <= ver_d;
        kind_q      <= kind_d;
        dcnt_q      <= dcnt_d;
        scnt_q      <= scnt_d;
        rem_q       <= rem_d;
        acc_q       <= acc_d;
        vleft_q     <= vleft_d;
        tok_start_q <= tok_start_d;
        tok_size_q  <= tok_size_d;
        pay_start_q <= pay_start_d;
        pay_size_q  <= pay_size_d;
      end
    end
  end

endmodule

FILE: design/qihp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qihp_out_reg
// Result register; holds one tagged byte result until the sink takes it.
// ----------------------------------------------------------------------------
module qihp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           advance_o,
  input  qihp_pkg::res_t result_i,
  output logic           valid_o,
  input  logic           ready_i,
  output qihp_pkg::res_t result_o
);

  logic           valid_q;
  qihp_pkg::res_t result_q;

  assign advance_o = !valid_q || ready_i;
  assign valid_o   = valid_q;
  assign result_o  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: design/quic_initial_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quic_initial_header_parser
// Tags each datagram byte with its QUIC Initial long-header field and reports
// a status and the field offsets and lengths on the last byte.
// ----------------------------------------------------------------------------
// One byte can be taken every clock cycle and its result is offered on the
// result port once it has passed the input register, the per-byte phase and
// counter update and the result register; back pressure on the result
// side stalls the input only when both registers are full. Every result
// carries the byte class; status and summary fields are set only on the
// result flagged by tlast and are zero unless the status is ok. Configuration
// writes take effect on the next clock edge and belong between datagrams
// while the pipeline is empty.
module quic_initial_header_parser #(
  parameter int MAX_PACKET_BYTES = qihp_pkg::MaxPacketBytes,
  parameter int MAX_CID_BYTES    = qihp_pkg::MaxCidBytes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // data_byte
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // byte_class, status, is_version_two, dcid_length, scid_length, token start,
  // token_length, payload start, payload_length, zero fill
  output logic [qihp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  input  logic                           cfg_we_i,
  input  logic [qihp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qihp_pkg::CfgDataW-1:0]  cfg_data_i
);

  qihp_pkg::item_t in_item;
  qihp_pkg::item_t s1_item;
  qihp_pkg::res_t  s1_result;
  qihp_pkg::res_t  out_result;
  logic            s1_valid;
  logic            advance;

  assign in_item.data = s_axis_tdata_i;
  assign in_item.last = s_axis_tlast_i;

  qihp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (s1_valid),
    .advance_i (advance),
    .item_o    (s1_item)
  );

  qihp_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .MAX_CID_BYTES    (MAX_CID_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (s1_valid && advance),
    .item_i     (s1_item),
    .result_o   (s1_result)
  );

  qihp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .advance_o (advance),
    .result_i  (s1_result),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .result_o  (out_result)
  );

  assign m_axis_tlast_o = out_result.packet_done;
  assign m_axis_tdata_o = {7'b0,
                           out_result.payload_length,
                           out_result.payload_pos,
                           out_result.token_length,
                           out_result.token_pos,
                           out_result.scid_length,
                           out_result.dcid_length,
                           out_result.is_version_two,
                           out_result.status,
                           out_result.byte_class};

endmodule

FILE: design/qihp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qihp_checker
// Port-level checks of the header parser result stream.
// ----------------------------------------------------------------------------
module qihp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [qihp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic                           m_axis_tlast_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // status only on the last byte of a datagram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[5:4] == qihp_pkg::ST_OK)
    else $error("status set on a non-final byte");

  // summary fields only with an ok status on the last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (!m_axis_tlast_o || m_axis_tdata_o[5:4] != qihp_pkg::ST_OK)
      |-> m_axis_tdata_o[qihp_pkg::OutDataW-1:6] == '0)
    else $error("summary fields set without ok status");

  // byte class within its code range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[3:0] <= qihp_pkg::CLS_ERR)
    else $error("byte class out of range");

endmodule

bind quic_initial_header_parser qihp_checker u_qihp_checker (.*);
